### src/itaf_pkg.sv
package itaf_pkg;

    localparam logic [2:0] ACT_SDEC = 3'd0;
    localparam logic [2:0] ACT_UDEC = 3'd1;
    localparam logic [2:0] ACT_HEXL = 3'd2;
    localparam logic [2:0] ACT_HEXU = 3'd3;
    localparam logic [2:0] ACT_PTR  = 3'd4;

    localparam logic [1:0] SEL_DIGIT = 2'd0;
    localparam logic [1:0] SEL_ZERO  = 2'd1;
    localparam logic [1:0] SEL_X     = 2'd2;
    localparam logic [1:0] SEL_MINUS = 2'd3;

    localparam logic [7:0] ASCII_ZERO       = 8'd48;
    localparam logic [7:0] ASCII_X          = 8'd120;
    localparam logic [7:0] ASCII_MINUS      = 8'd45;
    localparam logic [7:0] ASCII_UPPER_BASE = 8'd55;
    localparam logic [7:0] ASCII_LOWER_BASE = 8'd87;

    localparam int BIN_WIDTH  = 32;
    localparam int DEC_DIGITS = 10;
    localparam int BCD_WIDTH  = 4 * DEC_DIGITS;
    localparam int WORD_WIDTH = 64;
    localparam int MAX_DIGITS = WORD_WIDTH / 4;

    typedef struct packed {
        logic       load;
        logic       conv_step;
        logic       shift;
        logic       emit;
        logic [1:0] char_sel;
        logic       last;
    } itaf_cmd_t;

    typedef struct packed {
        logic ptr;
        logic neg;
        logic dec;
        logic top_zero;
        logic ndig_one;
        logic conv_last;
    } itaf_status_t;

endpackage

### src/integer_to_ascii_formatter.sv
// integer to ascii formatter
// start with action and value is taken at a clock edge where busy is low.
// actions: signed decimal, unsigned decimal, hex lower, hex upper, pointer
// ("0x" then 64-bit lower-case hex). codes above pointer are dropped and
// leave busy low.
// each character comes out on character for one cycle with strobe high,
// most significant first; last marks the final character of the number.
// the receiver cannot stall: a word not taken in its strobe cycle is gone.
// the '0' of a pointer and the minus sign are emitted first, from the
// dispatch state; hex digits follow once leading zero nibbles are skipped;
// decimal runs a 32-step shift-add-3 conversion first, then skips leading
// zero digits. leading zero nibbles are dropped at one per cycle, then one
// character a cycle; how long busy stays high depends on the action alone
// (32-bit hex, pointer or decimal), never on the value, and a new start is
// taken only once busy is low again.
// reset clears the controller and the strobe; no word is pending after it.
module integer_to_ascii_formatter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [63:0] value,
    output logic [7:0]  character,
    output logic        last,
    output logic        strobe
);

    itaf_pkg::itaf_cmd_t    cmd;
    itaf_pkg::itaf_status_t status;

    itaf_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    itaf_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .action    (action),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .character (character),
        .last      (last),
        .strobe    (strobe)
    );

`ifndef SYNTH
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("word right after last");

    a_bad_action_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (action > itaf_pkg::ACT_PTR) |=> !busy)
        else $error("dropped action started work");

    a_good_action_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (action <= itaf_pkg::ACT_PTR) |=> busy)
        else $error("accepted action did not start");

    a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("word without work in progress");
`endif

endmodule

### src/itaf_ctrl.sv
module itaf_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [2:0]             action,
    input  itaf_pkg::itaf_status_t status,
    output itaf_pkg::itaf_cmd_t    cmd,
    output logic                   busy
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_PTRX     = 3'd2;
    localparam logic [2:0] S_CONV     = 3'd3;
    localparam logic [2:0] S_SKIP     = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.char_sel  = itaf_pkg::SEL_DIGIT;
        case (state_reg)
            S_IDLE:
            begin
                if (start && (action <= itaf_pkg::ACT_PTR))
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.ptr)
                begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = itaf_pkg::SEL_ZERO;
                    state_next   = S_PTRX;
                end
                else if (status.neg)
                begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = itaf_pkg::SEL_MINUS;
                    state_next   = S_CONV;
                end
                else if (status.dec)
                begin
                    state_next = S_CONV;
                end
                else
                begin
                    state_next = S_SKIP;
                end
            end
            S_PTRX:
            begin
                cmd.emit     = 1'b1;
                cmd.char_sel = itaf_pkg::SEL_X;
                state_next   = S_SKIP;
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (status.conv_last)
                begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (status.top_zero && !status.ndig_one)
                begin
                    cmd.shift = 1'b1;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit  = 1'b1;
                cmd.shift = 1'b1;
                cmd.last  = status.ndig_one;
                if (status.ndig_one)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### src/itaf_dp.sv
module itaf_dp
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [2:0]             action,
    input  logic [63:0]            value,
    input  itaf_pkg::itaf_cmd_t    cmd,
    output itaf_pkg::itaf_status_t status,
    output logic [7:0]             character,
    output logic                   last,
    output logic                   strobe
);

    localparam int CNT_W = $clog2(itaf_pkg::BIN_WIDTH);
    localparam int NDIG_W = $clog2(itaf_pkg::MAX_DIGITS + 1);
    localparam int PAD_W = itaf_pkg::WORD_WIDTH - itaf_pkg::BCD_WIDTH;
    localparam int HALF_W = itaf_pkg::WORD_WIDTH - itaf_pkg::BIN_WIDTH;

    logic                                 ptr_reg;
    logic                                 neg_reg;
    logic                                 dec_reg;
    logic                                 upper_reg;
    logic [itaf_pkg::BIN_WIDTH-1:0]       bin_reg;
    logic [itaf_pkg::BCD_WIDTH-1:0]       bcd_reg;
    logic [CNT_W-1:0]                     count_reg;
    logic [itaf_pkg::WORD_WIDTH-1:0]      digits_reg;
    logic [NDIG_W-1:0]                    ndig_reg;
    logic [7:0]                           character_reg;
    logic                                 last_reg;
    logic                                 strobe_reg;

    logic [itaf_pkg::BIN_WIDTH-1:0]       low;
    logic [itaf_pkg::BIN_WIDTH-1:0]       mag;
    logic                                 load_neg;
    logic                                 load_ptr;
    logic [itaf_pkg::BCD_WIDTH-1:0]       bcd_adj;
    logic [itaf_pkg::BCD_WIDTH-1:0]       bcd_next;
    logic [3:0]                           top_nib;
    logic [7:0]                           digit_char;
    logic [7:0]                           char_next;

    assign low      = value[itaf_pkg::BIN_WIDTH-1:0];
    assign load_neg = (action == itaf_pkg::ACT_SDEC) && low[itaf_pkg::BIN_WIDTH-1];
    assign load_ptr = (action == itaf_pkg::ACT_PTR);
    assign mag      = load_neg ? (~low + 1'b1) : low;
    assign top_nib  = digits_reg[itaf_pkg::WORD_WIDTH-1 -: 4];

    // add-3 adjust on every bcd digit ahead of the shift
    always_comb
    begin
        for (int i = 0; i < itaf_pkg::DEC_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
        bcd_next = {bcd_adj[itaf_pkg::BCD_WIDTH-2:0], bin_reg[itaf_pkg::BIN_WIDTH-1]};
    end

    always_comb
    begin
        if (top_nib < 4'd10)
        begin
            digit_char = itaf_pkg::ASCII_ZERO + {4'b0, top_nib};
        end
        else if (upper_reg)
        begin
            digit_char = itaf_pkg::ASCII_UPPER_BASE + {4'b0, top_nib};
        end
        else
        begin
            digit_char = itaf_pkg::ASCII_LOWER_BASE + {4'b0, top_nib};
        end
        case (cmd.char_sel)
            itaf_pkg::SEL_ZERO:  char_next = itaf_pkg::ASCII_ZERO;
            itaf_pkg::SEL_X:     char_next = itaf_pkg::ASCII_X;
            itaf_pkg::SEL_MINUS: char_next = itaf_pkg::ASCII_MINUS;
            default:             char_next = digit_char;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ptr_reg    <= load_ptr;
            neg_reg    <= load_neg;
            dec_reg    <= (action <= itaf_pkg::ACT_UDEC);
            upper_reg  <= (action == itaf_pkg::ACT_HEXU);
            bin_reg    <= mag;
            bcd_reg    <= '0;
            count_reg  <= CNT_W'(itaf_pkg::BIN_WIDTH - 1);
            digits_reg <= load_ptr ? value : {low, {HALF_W{1'b0}}};
            ndig_reg   <= load_ptr ? NDIG_W'(itaf_pkg::MAX_DIGITS)
                                   : NDIG_W'(itaf_pkg::BIN_WIDTH / 4);
        end
        else if (cmd.conv_step)
        begin
            bin_reg   <= {bin_reg[itaf_pkg::BIN_WIDTH-2:0], 1'b0};
            bcd_reg   <= bcd_next;
            count_reg <= count_reg - 1'b1;
            if (count_reg == '0)
            begin
                digits_reg <= {bcd_next, {PAD_W{1'b0}}};
                ndig_reg   <= NDIG_W'(itaf_pkg::DEC_DIGITS);
            end
        end
        else if (cmd.shift)
        begin
            digits_reg <= {digits_reg[itaf_pkg::WORD_WIDTH-5:0], 4'b0};
            ndig_reg   <= ndig_reg - 1'b1;
        end
        if (cmd.emit)
        begin
            character_reg <= char_next;
            last_reg      <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
        end
    end

    assign status.ptr       = ptr_reg;
    assign status.neg       = neg_reg;
    assign status.dec       = dec_reg;
    assign status.top_zero  = (top_nib == 4'd0);
    assign status.ndig_one  = (ndig_reg == NDIG_W'(1));
    assign status.conv_last = (count_reg == '0);

    assign character = character_reg;
    assign last      = last_reg;
    assign strobe    = strobe_reg;

endmodule

### verif/itaf_checker.sv
module itaf_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  action,
    input  logic [63:0] value,
    input  logic [7:0]  character,
    input  logic        last,
    input  logic        strobe,
    output int          fail_count,
    output int          chars_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] code;
        logic       final_char;
    } char_word_t;

    char_word_t expected_chars[$];
    int         mismatches = 0;
    int         outstanding = 0;

    assign fail_count    = mismatches;
    assign chars_pending = outstanding;

    // text of one number, prefix first, then digits most significant first
    function automatic void format_integer(input logic [2:0] act, input logic [63:0] val);
        logic [7:0]  text[$];
        logic [7:0]  digits[$];
        logic [63:0] mag;
        logic [4:0]  base;
        logic [7:0]  alpha_base;
        logic [3:0]  digit;
        char_word_t  w;
        mag = {32'd0, val[31:0]};
        base = 5'd10;
        alpha_base = itaf_pkg::ASCII_LOWER_BASE;
        case (act)
            itaf_pkg::ACT_SDEC:
            begin
                if (val[31])
                begin
                    text.push_back(itaf_pkg::ASCII_MINUS);
                    mag[31:0] = ~val[31:0] + 32'd1;
                end
            end
            itaf_pkg::ACT_UDEC: ;
            itaf_pkg::ACT_HEXL: base = 5'd16;
            itaf_pkg::ACT_HEXU:
            begin
                base = 5'd16;
                alpha_base = itaf_pkg::ASCII_UPPER_BASE;
            end
            itaf_pkg::ACT_PTR:
            begin
                text.push_back(itaf_pkg::ASCII_ZERO);
                text.push_back(itaf_pkg::ASCII_X);
                mag = val;
                base = 5'd16;
            end
            default: return;
        endcase
        do
        begin
            digit = 4'(mag % base);
            digits.push_front((digit < 4'd10) ? itaf_pkg::ASCII_ZERO + 8'(digit)
                                              : alpha_base + 8'(digit));
            mag = mag / base;
        end
        while (mag != 64'd0);
        foreach (digits[i])
            text.push_back(digits[i]);
        foreach (text[i])
        begin
            w.code = text[i];
            w.final_char = (i == text.size() - 1);
            expected_chars.push_back(w);
        end
    endfunction

    always @(posedge clk)
    begin
        char_word_t due;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: word with nothing expected: character %h last %b",
                             $time, character, last);
                    mismatches++;
                end
                else
                begin
                    due = expected_chars.pop_front();
                    if (character !== due.code)
                    begin
                        $display("%0t: character expected %h actual %h",
                                 $time, due.code, character);
                        mismatches++;
                    end
                    if (last !== due.final_char)
                    begin
                        $display("%0t: last expected %b actual %b",
                                 $time, due.final_char, last);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                format_integer(action, value);
            outstanding = expected_chars.size();
        end
    end

endmodule

### verif/integer_to_ascii_formatter_tb.sv
module integer_to_ascii_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ACT_UNUSED_FIRST = itaf_pkg::ACT_PTR + 3'd1;
    localparam logic [2:0] ACT_TOP_CODE     = '1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  action = itaf_pkg::ACT_SDEC;
    logic [63:0] value = '0;
    logic        busy;
    logic [7:0]  character;
    logic        last;
    logic        strobe;
    int          fail_count;
    int          chars_pending;
    int          idle_pct = 0;

    integer_to_ascii_formatter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .value     (value),
        .character (character),
        .last      (last),
        .strobe    (strobe)
    );

    itaf_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .value         (value),
        .character     (character),
        .last          (last),
        .strobe        (strobe),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    // offer one word and hold it until taken
    task automatic send_word(input logic [2:0] act, input logic [63:0] val);
        bit taken;
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(24, 1)) @(posedge clk);
        end
        start  <= 1'b1;
        action <= act;
        value  <= val;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (chars_pending != 0);
        @(posedge clk);
    endtask

    function automatic logic [2:0] random_action();
        if ($urandom_range(99, 0) < 6)
            return 3'($urandom_range(ACT_TOP_CODE, ACT_UNUSED_FIRST));
        return 3'($urandom_range(itaf_pkg::ACT_PTR, itaf_pkg::ACT_SDEC));
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int          shape;
        v = {$urandom, $urandom};
        shape = $urandom_range(3, 0);
        if (shape == 1)
            v = v >> $urandom_range(63, 0);
        else if (shape == 2)
            v = {32'($urandom), 32'($urandom_range(20, 0))};
        else if (shape == 3)
            v = {32'($urandom), -32'($urandom_range(20, 1))};
        return v;
    endfunction

    task automatic random_phase(input int pct, input int count);
        idle_pct = pct;
        repeat (count) send_word(random_action(), random_value());
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 18;
        send_word(itaf_pkg::ACT_SDEC, 64'd0);
        send_word(itaf_pkg::ACT_SDEC, 64'd1);
        send_word(itaf_pkg::ACT_SDEC, 64'h0000_0000_FFFF_FFFF);
        send_word(itaf_pkg::ACT_SDEC, 64'hFFFF_FFFF_7FFF_FFFF);
        send_word(itaf_pkg::ACT_SDEC, 64'hAAAA_AAAA_8000_0000);
        send_word(itaf_pkg::ACT_UDEC, 64'd0);
        send_word(itaf_pkg::ACT_UDEC, 64'h5555_5555_FFFF_FFFF);
        send_word(itaf_pkg::ACT_UDEC, 64'd1234567890);
        send_word(itaf_pkg::ACT_UDEC, 64'd1000000000);
        send_word(itaf_pkg::ACT_HEXL, 64'd0);
        send_word(itaf_pkg::ACT_HEXL, 64'hFFFF_FFFF_DEAD_BEEF);
        send_word(itaf_pkg::ACT_HEXL, 64'h0000_0000_FFFF_FFFF);
        send_word(itaf_pkg::ACT_HEXU, 64'd0);
        send_word(itaf_pkg::ACT_HEXU, 64'h1234_5678_ABCD_EF01);
        send_word(itaf_pkg::ACT_HEXU, 64'h0000_0000_FFFF_FFFF);
        send_word(itaf_pkg::ACT_PTR, 64'd0);
        send_word(itaf_pkg::ACT_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(itaf_pkg::ACT_PTR, 64'd1);
        send_word(itaf_pkg::ACT_PTR, 64'h8000_0000_0000_0000);
        send_word(itaf_pkg::ACT_PTR, 64'h0123_4567_89AB_CDEF);
        send_word(itaf_pkg::ACT_PTR, 64'hAAAA_AAAA_5555_5555);
        send_word(ACT_UNUSED_FIRST, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(ACT_UNUSED_FIRST + 3'd1, 64'd0);
        send_word(ACT_TOP_CODE, 64'h5555_5555_AAAA_AAAA);
        send_word(itaf_pkg::ACT_HEXL, 64'd10);
        wait_drained();

        random_phase(18, 60);
        random_phase(81, 60);
        random_phase(0, 60);

        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
